### rtl/frs_pkg.sv
// Shared constants, codes and types of the two-stream fragment reassembler.
// No dependencies; all rtl/ files but frs_ram import this package.
package frs_pkg;

  // Fragment layout and buffer sizes
  localparam int FRAGMENT_STRIDE = 250;
  localparam int BITMAP_SLOTS    = 8;
  localparam int BITMAP_BYTES    = 1024;
  localparam int IMAGE_SLOTS     = 140;
  localparam int IMAGE_BYTES     = 32 * 1024;

  // Header type bytes ('I' and 'J') and the frame position cutoff
  localparam logic [7:0] TYPE_BITMAP = 8'h49;
  localparam logic [7:0] TYPE_IMAGE  = 8'h4A;
  localparam logic [7:0] FRAME_LIMIT = 8'd254;

  // Seen-map memory: bitmap slots first, image slots after them
  localparam int MAP_DEPTH = BITMAP_SLOTS + IMAGE_SLOTS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int EPOCH_W   = 4;

  // Counter widths
  localparam int BM_CW  = $clog2(BITMAP_SLOTS + 1);
  localparam int IMG_CW = $clog2(IMAGE_SLOTS + 1);

  // Output word packing
  localparam int TDATA_W = 56;
  localparam int TUSER_W = 3;

  // Result kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Frame status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_BAD     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_BEYOND  = 3'd4;
  localparam logic [2:0] ST_SHORT   = 3'd5;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic        stream;
    logic [14:0] byte_address;
    logic [7:0]  byte_value;
    logic [2:0]  status_code;
    logic        transfer_complete;
    logic [15:0] image_size;
    logic [7:0]  received_count;
    logic        run_last;
  } result_t;

  // Parser to seen-map requests
  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              rd_img;
    logic              wr_en;
    logic              clr_bm;
    logic              clr_img;
  } map_req_t;

endpackage

### rtl/frs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module frs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/frs_seen_map.sv
// Fragment seen-map of both streams: epoch tags in a RAM, per-entry valid flops.
// Depends on frs_pkg and frs_ram.
module frs_seen_map import frs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  map_req_t req,
  output logic     seen
);

  localparam logic [MAP_DEPTH-1:0] BM_MASK =
    {{IMAGE_SLOTS{1'b0}}, {BITMAP_SLOTS{1'b1}}};

  logic [MAP_DEPTH-1:0] valid;
  logic [MAP_DEPTH-1:0] valid_next;
  logic [EPOCH_W-1:0]   ep_bm;
  logic [EPOCH_W-1:0]   ep_img;
  logic [EPOCH_W-1:0]   ep_bm_next;
  logic [EPOCH_W-1:0]   ep_img_next;
  logic [MAP_AW-1:0]    addr_q;
  logic                 img_q;
  logic [EPOCH_W-1:0]   tag_rd;
  logic [EPOCH_W-1:0]   tag_wr;

  // A clear bumps the stream epoch; old tags stop matching
  assign ep_bm_next  = req.clr_bm  ? ep_bm + 1'b1  : ep_bm;
  assign ep_img_next = req.clr_img ? ep_img + 1'b1 : ep_img;
  assign tag_wr      = img_q ? ep_img_next : ep_bm_next;

  // Tag memory, written back at the entry looked up for this frame
  frs_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (MAP_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (addr_q),
    .wdata (tag_wr),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (tag_rd)
  );

  // Entry seen when written under the current epoch
  assign seen = valid[addr_q] && (tag_rd == (img_q ? ep_img : ep_bm));

  // Valid bits: set on a write, dropped for a stream when its epoch wraps
  always_comb begin
    valid_next = valid;
    if (req.clr_bm && (ep_bm == '1)) begin
      valid_next = valid_next & ~BM_MASK;
    end
    if (req.clr_img && (ep_img == '1)) begin
      valid_next = valid_next & BM_MASK;
    end
    if (req.wr_en) begin
      valid_next[addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      ep_bm  <= '0;
      ep_img <= '0;
      addr_q <= '0;
      img_q  <= 1'b0;
    end else begin
      valid  <= valid_next;
      ep_bm  <= ep_bm_next;
      ep_img <= ep_img_next;
      if (req.rd_en) begin
        addr_q <= req.rd_addr;
        img_q  <= req.rd_img;
      end
    end
  end

endmodule

### rtl/frs_parse.sv
// Frame header parser and stream bookkeeping; produces up to two results per byte.
// Depends on frs_pkg; drives the seen-map requests.
module frs_parse import frs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] frame_byte,
  input  logic       frame_end,
  input  logic       seen,
  output map_req_t   map_req,
  output logic       a_valid,
  output result_t    res_a,
  output logic       b_valid,
  output result_t    res_b
);

  logic [7:0]        pos, pos_next;
  logic [7:0]        htype, htype_next;
  logic [7:0]        hindex, hindex_next;
  logic [7:0]        htotal, htotal_next;
  logic [7:0]        hlength, hlength_next;
  logic [2:0]        verdict, verdict_next;
  logic [15:0]       index_base, index_base_next;
  logic [7:0]        bm_total, bm_total_next;
  logic [BM_CW-1:0]  bm_count, bm_count_next;
  logic [7:0]        img_total, img_total_next;
  logic [IMG_CW-1:0] img_count, img_count_next;
  logic [7:0]        img_last, img_last_next;

  logic        is_bm;
  logic        is_img;
  logic        rd_in_range;
  logic [8:0]  rd_sum;
  logic [16:0] end_sum;
  logic [7:0]  pay_off;
  logic [15:0] pay_addr;

  assign is_bm    = (htype == TYPE_BITMAP);
  assign is_img   = (htype == TYPE_IMAGE);
  assign end_sum  = {1'b0, index_base} + 17'(frame_byte);
  assign pay_off  = pos - 8'd4;
  assign pay_addr = index_base + 16'(pay_off);

  // Seen-map address of the incoming index byte
  assign rd_in_range = (is_bm && (frame_byte < 8'(BITMAP_SLOTS))) ||
                       (is_img && (frame_byte < 8'(IMAGE_SLOTS)));
  assign rd_sum      = 9'(frame_byte) + (is_img ? 9'(BITMAP_SLOTS) : 9'd0);

  always_comb begin
    logic        clr;
    logic        done;
    logic [7:0]  tm1;
    logic [15:0] prod;

    pos_next        = pos;
    htype_next      = htype;
    hindex_next     = hindex;
    htotal_next     = htotal;
    hlength_next    = hlength;
    verdict_next    = verdict;
    index_base_next = index_base;
    bm_total_next   = bm_total;
    bm_count_next   = bm_count;
    img_total_next  = img_total;
    img_count_next  = img_count;
    img_last_next   = img_last;
    map_req         = '0;
    a_valid         = 1'b0;
    res_a           = '0;
    b_valid         = 1'b0;
    res_b           = '0;
    clr             = 1'b0;
    done            = 1'b0;
    tm1             = '0;
    prod            = '0;

    if (accept) begin
      case (pos)
        8'd0: begin
          htype_next = frame_byte;
        end
        8'd1: begin
          hindex_next     = frame_byte;
          index_base_next = 16'(frame_byte) * 16'(FRAGMENT_STRIDE);
          map_req.rd_en   = 1'b1;
          map_req.rd_img  = is_img;
          map_req.rd_addr = rd_in_range ? MAP_AW'(rd_sum) : '0;
        end
        8'd2: begin
          htotal_next = frame_byte;
        end
        8'd3: begin
          // Header complete: stream decisions
          hlength_next = frame_byte;
          if (is_bm) begin
            if ((hindex >= 8'(BITMAP_SLOTS)) || (frame_byte > 8'(FRAGMENT_STRIDE))) begin
              verdict_next = ST_BAD;
            end else begin
              clr = (bm_total == 8'd0) || (htotal != bm_total);
              if (clr) begin
                map_req.clr_bm = 1'b1;
                bm_total_next  = htotal;
                bm_count_next  = '0;
                a_valid        = 1'b1;
                res_a.kind     = KIND_CLEAR;
              end
              if (seen && !clr) begin
                verdict_next = ST_DUP;
              end else if (end_sum > 17'(BITMAP_BYTES)) begin
                verdict_next = ST_BEYOND;
              end else begin
                map_req.wr_en = 1'b1;
                bm_count_next = bm_count_next + 1'b1;
                verdict_next  = ST_STORED;
              end
            end
          end else if (is_img) begin
            if ((hindex >= 8'(IMAGE_SLOTS)) || (frame_byte > 8'(FRAGMENT_STRIDE))) begin
              verdict_next = ST_BAD;
            end else begin
              clr = (img_total == 8'd0) || (htotal != img_total);
              if (clr) begin
                map_req.clr_img = 1'b1;
                img_total_next  = htotal;
                img_count_next  = '0;
                a_valid         = 1'b1;
                res_a.kind      = KIND_CLEAR;
                res_a.stream    = 1'b1;
              end
              if (seen && !clr) begin
                verdict_next = ST_DUP;
              end else if (end_sum > 17'(IMAGE_BYTES)) begin
                verdict_next = ST_BEYOND;
              end else begin
                map_req.wr_en  = 1'b1;
                img_count_next = img_count_next + 1'b1;
                verdict_next   = ST_STORED;
                if (hindex == (htotal - 8'd1)) begin
                  img_last_next = frame_byte;
                end
              end
            end
          end else begin
            verdict_next = ST_UNKNOWN;
          end
        end
        default: begin
          // Payload byte write
          if ((pos < FRAME_LIMIT) && (verdict == ST_STORED) && (is_bm || is_img) &&
              (pay_off < hlength)) begin
            a_valid            = 1'b1;
            res_a.kind         = KIND_WRITE;
            res_a.stream       = is_img;
            res_a.byte_address = pay_addr[14:0];
            res_a.byte_value   = frame_byte;
          end
        end
      endcase

      // Frame end: status word and completion check
      if (frame_end) begin
        b_valid    = 1'b1;
        res_b.kind = KIND_STATUS;
        if (pos < 8'd3) begin
          res_b.status_code = ST_SHORT;
        end else if (verdict_next == ST_UNKNOWN) begin
          res_b.status_code = ST_UNKNOWN;
        end else if (is_bm) begin
          done = (verdict_next != ST_BAD) && (8'(bm_count_next) == bm_total_next);
          res_b.status_code       = verdict_next;
          res_b.transfer_complete = done;
          res_b.received_count    = 8'(bm_count_next);
          if (done) begin
            bm_total_next = 8'd0;
          end
        end else begin
          done = (verdict_next != ST_BAD) && (8'(img_count_next) == img_total_next);
          tm1  = img_total_next - 8'd1;
          prod = 16'(tm1) * 16'(FRAGMENT_STRIDE);
          res_b.stream            = 1'b1;
          res_b.status_code       = verdict_next;
          res_b.transfer_complete = done;
          res_b.received_count    = 8'(img_count_next);
          if (done && (img_total_next != 8'd0)) begin
            res_b.image_size = prod + 16'(img_last_next);
          end
          if (done) begin
            img_total_next = 8'd0;
          end
        end
        pos_next = 8'd0;
      end else if (pos != 8'd255) begin
        pos_next = pos + 8'd1;
      end

      // Mark the last result of this byte
      if (b_valid) begin
        res_b.run_last = 1'b1;
      end else begin
        res_a.run_last = a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      htype      <= '0;
      hindex     <= '0;
      htotal     <= '0;
      hlength    <= '0;
      verdict    <= ST_STORED;
      index_base <= '0;
      bm_total   <= '0;
      bm_count   <= '0;
      img_total  <= '0;
      img_count  <= '0;
      img_last   <= '0;
    end else begin
      pos        <= pos_next;
      htype      <= htype_next;
      hindex     <= hindex_next;
      htotal     <= htotal_next;
      hlength    <= hlength_next;
      verdict    <= verdict_next;
      index_base <= index_base_next;
      bm_total   <= bm_total_next;
      bm_count   <= bm_count_next;
      img_total  <= img_total_next;
      img_count  <= img_count_next;
      img_last   <= img_last_next;
    end
  end

endmodule

### rtl/frs_outq.sv
// Four-word result queue: takes up to two words per cycle, hands out one.
// Depends on frs_pkg.
module frs_outq import frs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_a,
  input  result_t res_a,
  input  logic    push_b,
  input  result_t res_b,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  result_t            q [Q_DEPTH];
  logic [Q_AW-1:0]    wp;
  logic [Q_AW-1:0]    rp;
  logic [Q_AW:0]      count;
  logic [Q_AW:0]      count_next;
  logic               pop;
  logic [Q_AW-1:0]    wp_b;

  assign room      = (count <= (Q_AW + 1)'(Q_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_word  = q[rp];
  assign pop       = out_valid && out_ready;
  assign wp_b      = push_a ? wp + 1'b1 : wp;

  assign count_next = count + (Q_AW + 1)'(push_a) + (Q_AW + 1)'(push_b) -
                      (Q_AW + 1)'(pop);

  // Storage
  always_ff @(posedge clk) begin
    if (push_a) begin
      q[wp] <= res_a;
    end
    if (push_b) begin
      q[wp_b] <= res_b;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push_b) begin
        wp <= wp_b + 1'b1;
      end else if (push_a) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

### rtl/two_stream_fragment_reassembler_core.sv
// Top level of the two-stream fragment reassembler.
// Depends on frs_pkg, frs_parse, frs_seen_map (with frs_ram) and frs_outq.
//
//   port group  dir  carries
//   s_*         in   one frame byte per word; tlast marks the frame's last byte
//   m_*         out  clear, byte write or frame status words; tlast ends a byte's run
//
// One byte is taken per cycle while s_tready is high; each byte gives zero, one
// or two result words, which queue behind any words already waiting on m_*.
// The fragment index is looked up in the seen-map RAM on header byte 1 and
// read back, checked and written on header byte 3 (the RAM read port is registered).
// A four-word output queue parts the sides; s_tready drops while fewer than
// two free slots remain, so a stall on m_tready holds the input once three words wait.
// Reset (rst, synchronous) clears all control flops at once; memories need no clearing pass.
module two_stream_fragment_reassembler_core import frs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] frame_byte
  input  logic               s_tlast,   // frame_end
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [14:0] byte_address, [22:15] byte_value,
                                        // [25:23] status_code, [26] transfer_complete,
                                        // [42:27] image_size, [50:43] received_count,
                                        // [55:51] zero
  output logic [TUSER_W-1:0] m_tuser,   // [1:0] kind, [2] stream
  output logic               m_tlast    // run_last
);

  logic     accept;
  logic     room;
  logic     seen;
  map_req_t map_req;
  logic     a_valid;
  logic     b_valid;
  result_t  res_a;
  result_t  res_b;
  result_t  head;

  assign s_tready = room;
  assign accept   = s_tvalid && room;

  frs_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (s_tdata),
    .frame_end  (s_tlast),
    .seen       (seen),
    .map_req    (map_req),
    .a_valid    (a_valid),
    .res_a      (res_a),
    .b_valid    (b_valid),
    .res_b      (res_b)
  );

  frs_seen_map u_map (
    .clk  (clk),
    .rst  (rst),
    .req  (map_req),
    .seen (seen)
  );

  frs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_a    (a_valid),
    .res_a     (res_a),
    .push_b    (b_valid),
    .res_b     (res_b),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (head)
  );

  // Output word packing
  assign m_tdata = {5'd0, head.received_count, head.image_size, head.transfer_complete,
                    head.status_code, head.byte_value, head.byte_address};
  assign m_tuser = {head.stream, head.kind};
  assign m_tlast = head.run_last;

endmodule
